### design/u16rb_pkg.sv
// shared types, constants and helpers of the uart 16550 register block
package u16rb_pkg;

   // receive fifo depth and derived widths
   localparam int RX_DEPTH = 16;
   localparam int ADDR_W   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int FILL_W   = $clog2(RX_DEPTH + 1);
   localparam int SUM_W    = FILL_W + 1;

   // response queue depth
   localparam int RSP_QDEPTH = 3;
   localparam int RSP_QAW    = $clog2(RSP_QDEPTH);
   localparam int RSP_QCW    = $clog2(RSP_QDEPTH + 1);

   // request kinds
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2
   } op_type;

   // register offsets
   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER  = 3'd1;
   localparam logic [2:0] REG_IIR  = 3'd2;
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;

   // register bit codes
   localparam logic [7:0] LCR_DLAB      = 8'h80;
   localparam logic [7:0] LSR_DR        = 8'h01;
   localparam logic [7:0] LSR_OE        = 8'h02;
   localparam logic [7:0] LSR_THRE_TEMT = 8'h60;
   localparam logic [7:0] IIR_FIFO      = 8'hC0;
   localparam logic [7:0] IIR_RDA       = 8'h04;
   localparam logic [7:0] IIR_NONE      = 8'h01;
   localparam int         MCR_OUT2_BIT  = 3;
   localparam int         MCR_LOOP_BIT  = 4;
   localparam int         FCR_EN_BIT    = 0;
   localparam int         FCR_FLUSH_BIT = 1;

   // one response item
   typedef struct packed {
      logic       irq;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [7:0] read_data;
   } rsp_item_type;

   // head plus offset, folded back into the fifo
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] folded;
      folded = (sum >= SUM_W'(RX_DEPTH)) ? sum - SUM_W'(RX_DEPTH) : sum;
      return folded[ADDR_W-1:0];
   endfunction

endpackage

### design/u16rb_ram.sv
// generic single-write, single-read ram with registered read data
module u16rb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/u16rb_rsp_queue.sv
// small response queue that parts the pipeline from the result channel
module u16rb_rsp_queue import u16rb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_item_type       push_item,
   output logic [RSP_QCW-1:0] count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_item_type       rsp_item
);

   rsp_item_type       entry_ff [RSP_QDEPTH];
   logic [RSP_QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_QCW-1:0] count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_QAW'(RSP_QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_QAW'(RSP_QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/uart_16550_register_block.sv
// uart 16550 register block: bus register file with receive fifo in ram
// a request's response is offered once it has passed the ram read stage register
// (which holds the registered fifo ram read) and then been written into the response queue
// throughput: one request per cycle while req_tready is high; it drops when the response queue has no room
// a three-entry response queue keeps requests flowing while responses are held back
// reset: synchronous, active high; clears the register state, the fifo pointers and the
// pipeline valid flags, not the fifo ram (entries are only read once written)
module uart_16550_register_block import u16rb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // reg_offset[2:0], write_data[10:3], line_byte[18:11]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_data[7:0], tx_valid[8], tx_byte[16:9], irq[17]
);

   // register state
   logic [7:0]        dll_ff, dll_in;
   logic [7:0]        dlm_ff, dlm_in;
   logic [3:0]        ier_ff, ier_in;
   logic [7:0]        lcr_ff, lcr_in;
   logic [4:0]        mcr_ff, mcr_in;
   logic [7:0]        scr_ff, scr_in;
   logic              fifo_en_ff, fifo_en_in;
   logic [1:0]        trig_ff, trig_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              overrun_ff, overrun_in;

   // ram read stage
   logic              p_valid_ff;
   logic              p_pop_ff, p_pop_in;
   rsp_item_type      p_item_ff, p_item_in;

   // request fields
   logic              req_accept;
   op_type            op;
   logic [2:0]        reg_offset;
   logic [7:0]        write_data;
   logic [7:0]        line_byte;

   // fifo ram access
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [7:0]        ram_rd_data;

   // response queue
   logic [RSP_QCW-1:0] q_count;
   rsp_item_type       q_push_item;
   rsp_item_type       rsp_item;

   // control helpers
   logic              dlab;
   logic              loop;
   logic              push;
   logic [7:0]        push_byte;
   logic              fifo_full;
   logic              fcr_en;

   assign op         = op_type'(req_tuser);
   assign reg_offset = req_tdata[2:0];
   assign write_data = req_tdata[10:3];
   assign line_byte  = req_tdata[18:11];

   // room for the item in flight plus this one in the response queue
   assign req_tready = (({1'b0, q_count} + {{RSP_QCW{1'b0}}, p_valid_ff})
                        < (RSP_QCW + 1)'(RSP_QDEPTH));
   assign req_accept = req_tvalid && req_tready;

   assign dlab      = lcr_ff[7];
   assign loop      = mcr_ff[MCR_LOOP_BIT];
   assign fifo_full = fill_ff >= (fifo_en_ff ? FILL_W'(RX_DEPTH) : FILL_W'(1));
   assign fcr_en    = write_data[FCR_EN_BIT];

   always_comb begin
      dll_in      = dll_ff;
      dlm_in      = dlm_ff;
      ier_in      = ier_ff;
      lcr_in      = lcr_ff;
      mcr_in      = mcr_ff;
      scr_in      = scr_ff;
      fifo_en_in  = fifo_en_ff;
      trig_in     = trig_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      overrun_in  = overrun_ff;
      p_pop_in    = 1'b0;
      p_item_in   = '0;
      push        = 1'b0;
      push_byte   = line_byte;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wrap_addr({{(SUM_W-ADDR_W){1'b0}}, head_ff} + {1'b0, fill_ff});
      ram_wr_data = push_byte;

      if (req_accept) begin
         case (op)
            OP_READ: begin
               case (reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        p_item_in.read_data = dll_ff;
                     end else if (fill_ff != '0) begin
                        // data comes from the ram next cycle
                        p_pop_in = 1'b1;
                        head_in  = (head_ff == ADDR_W'(RX_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                        fill_in  = fill_ff - 1'b1;
                     end
                  end
                  REG_IER: begin
                     p_item_in.read_data = dlab ? dlm_ff : {4'b0, ier_ff};
                  end
                  REG_IIR: begin
                     p_item_in.read_data = (ier_ff[0] && fill_ff != '0) ? IIR_RDA : IIR_NONE;
                     if (fifo_en_ff) begin
                        p_item_in.read_data = p_item_in.read_data | IIR_FIFO;
                     end
                  end
                  REG_LCR: begin
                     p_item_in.read_data = lcr_ff;
                  end
                  REG_MCR: begin
                     p_item_in.read_data = {3'b0, mcr_ff};
                  end
                  REG_LSR: begin
                     p_item_in.read_data = LSR_THRE_TEMT
                                         | ((fill_ff != '0) ? LSR_DR : 8'h00)
                                         | (overrun_ff ? LSR_OE : 8'h00);
                     overrun_in = 1'b0;
                  end
                  REG_MSR: begin
                     // loopback shows rts, dtr, out1, out2 on the modem inputs
                     if (loop) begin
                        p_item_in.read_data = {mcr_ff[3], mcr_ff[2], mcr_ff[0], mcr_ff[1], 4'b0};
                     end
                  end
                  REG_SCR: begin
                     p_item_in.read_data = scr_ff;
                  end
                  default: begin
                     p_item_in.read_data = scr_ff;
                  end
               endcase
            end
            OP_WRITE: begin
               case (reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        dll_in = write_data;
                     end else if (loop) begin
                        push      = 1'b1;
                        push_byte = write_data;
                     end else begin
                        p_item_in.tx_valid = 1'b1;
                        p_item_in.tx_byte  = write_data;
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        dlm_in = write_data;
                     end else begin
                        ier_in = write_data[3:0];
                     end
                  end
                  REG_IIR: begin
                     // fcr: flush on request or on a change of fifo mode
                     if (write_data[FCR_FLUSH_BIT] || (fcr_en != fifo_en_ff)) begin
                        head_in = '0;
                        fill_in = '0;
                     end
                     fifo_en_in = fcr_en;
                     trig_in    = write_data[7:6];
                  end
                  REG_LCR: begin
                     lcr_in = write_data;
                  end
                  REG_MCR: begin
                     mcr_in = write_data[4:0];
                  end
                  REG_SCR: begin
                     scr_in = write_data;
                  end
                  default: begin
                  end
               endcase
            end
            OP_LINE: begin
               // receiver is cut off from the line in loopback
               push = !loop;
            end
            default: begin
            end
         endcase

         if (push) begin
            ram_wr_data = push_byte;
            if (fifo_full) begin
               overrun_in = 1'b1;
               // holding register mode: newest byte replaces the held one
               if (!fifo_en_ff && fill_ff != '0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wrap_addr({{(SUM_W-ADDR_W){1'b0}}, head_ff}
                                          + {1'b0, fill_ff} - 1'b1);
               end
            end else begin
               ram_wr_en = 1'b1;
               fill_in   = fill_ff + 1'b1;
            end
         end

         // interrupt reflects the state after this request
         p_item_in.irq = ier_in[0] && (fill_in != '0) && mcr_in[MCR_OUT2_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dll_ff     <= '0;
         dlm_ff     <= '0;
         ier_ff     <= '0;
         lcr_ff     <= '0;
         mcr_ff     <= '0;
         scr_ff     <= '0;
         fifo_en_ff <= 1'b0;
         trig_ff    <= '0;
         head_ff    <= '0;
         fill_ff    <= '0;
         overrun_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         dll_ff     <= dll_in;
         dlm_ff     <= dlm_in;
         ier_ff     <= ier_in;
         lcr_ff     <= lcr_in;
         mcr_ff     <= mcr_in;
         scr_ff     <= scr_in;
         fifo_en_ff <= fifo_en_in;
         trig_ff    <= trig_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         overrun_ff <= overrun_in;
         p_valid_ff <= req_accept;
      end
   end

   // payload of the ram read stage
   always_ff @(posedge clock) begin
      p_pop_ff  <= p_pop_in;
      p_item_ff <= p_item_in;
   end

   // receive fifo storage, read at the head every cycle
   u16rb_ram #(
      .WIDTH(8),
      .DEPTH(RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // merge the popped byte into the response
   always_comb begin
      q_push_item = p_item_ff;
      if (p_pop_ff) begin
         q_push_item.read_data = ram_rd_data;
      end
   end

   u16rb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (p_valid_ff),
      .push_item (q_push_item),
      .count     (q_count),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {6'b0, rsp_item.irq, rsp_item.tx_byte, rsp_item.tx_valid,
                       rsp_item.read_data};

endmodule
